// ----- sv/ldgd_pkg.sv -----
package ldgd_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int TIME_W    = 32;
  localparam int THR_W     = 11;
  localparam int LOOP_W    = 10;
  localparam int CAP_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CAL_CNT_W = 4;
  localparam int CAL_SUM_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD      = 2'd0,
    REG_LOOP_PERIOD    = 2'd1,
    REG_CAPTURE_PERIOD = 2'd2
  } cfg_reg_e;

  localparam logic CMD_CAL    = 1'b0;
  localparam logic CMD_DETECT = 1'b1;

  localparam logic [CAL_CNT_W-1:0] CAL_LAST   = 4'd9;   // tenth sample closes the batch
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 10'd1023;
  localparam logic [LOOP_W-1:0]    LOOP_RST   = 10'd50;
  localparam logic [CAP_W-1:0]     CAP_RST    = 16'd1000;

  localparam int SIDE_MIN_MS = 100;
  localparam int SIDE_MAX_MS = 1000;

  typedef struct packed {
    logic done;
    logic detected;
  } scan_rsp_t;

endpackage

// ----- sv/light_dip_gesture_detector.sv -----
// Light-dip gesture detector. Calibration beats (command 0) collect ten samples and set the
// reference to (sum - min - max) / 8. Detection beats (command 1) store the sample in a
// WINDOW_LENGTH-deep window RAM; while armed, a dip (reference minus sample) greater than
// threshold_counts starts a capture (threshold >= 0), and a dip less than it fires detected
// at once (threshold < 0). The first detection beat after capture_period_ms has elapsed is
// not stored; it scans the window RAM and reports evaluated = 1 with the gesture verdict.
// Calibration and plain detection beats pass through T_EXEC and T_OUT before the result
// is registered; an evaluating beat also waits in T_EVAL for the scan over the window RAM,
// which has a single read port (one read per cycle: a minimum pass over the window, then
// the rising and falling sides). Items are handled one at a time; a finished result waits
// in the output register while the next beat is taken. No clearing pass after reset is
// needed.
module light_dip_gesture_detector import ldgd_pkg::*; #(
  parameter int WINDOW_LENGTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic [TIME_W-1:0]    now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 detected_o,
  output logic                 evaluated_o,
  output logic [SAMPLE_W-1:0]  reference_level_o
);

  localparam int W  = WINDOW_LENGTH;
  localparam int AW = $clog2(W);

  typedef enum logic [1:0] {T_IDLE, T_EXEC, T_EVAL, T_OUT} state_e;

  state_e                     state_q;
  logic signed [THR_W-1:0]    thr_q;
  logic [LOOP_W-1:0]          lp_q;
  logic [CAP_W-1:0]           cap_q;
  logic [AW-1:0]              wp_q;
  logic                       armed_q;
  logic [TIME_W-1:0]          cap_start_q;
  logic [SAMPLE_W-1:0]        ref_q;
  logic [CAL_CNT_W-1:0]       cal_cnt_q;
  logic [CAL_SUM_W-1:0]       cal_sum_q;
  logic [SAMPLE_W-1:0]        cal_min_q;
  logic [SAMPLE_W-1:0]        cal_max_q;
  logic                       res_det_q;
  logic                       res_ev_q;
  logic                       scan_start_q;
  logic                       out_valid_q;
  logic                       det_out_q;
  logic                       ev_out_q;
  logic [SAMPLE_W-1:0]        ref_out_q;

  logic                       cmd_q;
  logic [SAMPLE_W-1:0]        sample_q;
  logic [TIME_W-1:0]          now_q;

  logic [TIME_W-1:0]          elapsed;
  logic                       eval_hit;
  logic                       thr_pos;
  logic signed [SAMPLE_W+1:0] dip;
  logic signed [SAMPLE_W+1:0] thr_ext;
  logic [CAL_SUM_W-1:0]       sum_new;
  logic [SAMPLE_W-1:0]        min_new;
  logic [SAMPLE_W-1:0]        max_new;
  logic [CAL_SUM_W-1:0]       trimmed;
  logic [AW-1:0]              wp_next;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       can_load;
  scan_rsp_t                  scan_rsp;

  assign in_stall_o = (state_q != T_IDLE);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && state_q == T_IDLE) begin
      cmd_q    <= command_i;
      sample_q <= sample_i;
      now_q    <= now_ms_i;
    end
  end

  assign elapsed  = now_q - cap_start_q;
  assign eval_hit = !armed_q && (elapsed >= TIME_W'(cap_q));
  assign thr_pos  = (thr_q > 0);
  assign dip      = $signed({2'b00, ref_q}) - $signed({2'b00, sample_q});
  assign thr_ext  = $signed({thr_q[THR_W-1], thr_q});

  assign sum_new = cal_sum_q + CAL_SUM_W'(sample_q);
  assign min_new = (sample_q < cal_min_q) ? sample_q : cal_min_q;
  assign max_new = (sample_q > cal_max_q) ? sample_q : cal_max_q;
  assign trimmed = sum_new - CAL_SUM_W'(min_new) - CAL_SUM_W'(max_new);

  // newest slot: old pointer when shifting, else the slot just behind it
  assign wp_next = (wp_q == AW'(W - 1)) ? '0 : wp_q + AW'(1);
  assign wr_addr = thr_pos ? wp_q : ((wp_q == '0) ? AW'(W - 1) : wp_q - AW'(1));
  assign wr_en   = (state_q == T_EXEC) && (cmd_q == CMD_DETECT) && !eval_hit;

  assign can_load = !out_valid_q || !out_stall_i;

  ldgd_scan #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (wr_en),
    .wr_addr_i     (wr_addr),
    .wr_data_i     (sample_q),
    .start_i       (scan_start_q),
    .wp_i          (wp_q),
    .loop_period_i (lp_q),
    .rsp_o         (scan_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_IDLE;
      thr_q        <= '0;
      lp_q         <= LOOP_RST;
      cap_q        <= CAP_RST;
      wp_q         <= '0;
      armed_q      <= 1'b1;
      cap_start_q  <= '0;
      ref_q        <= '0;
      cal_cnt_q    <= '0;
      cal_sum_q    <= '0;
      cal_min_q    <= SAMPLE_MAX;
      cal_max_q    <= '0;
      res_det_q    <= 1'b0;
      res_ev_q     <= 1'b0;
      scan_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      det_out_q    <= 1'b0;
      ev_out_q     <= 1'b0;
      ref_out_q    <= '0;
    end else begin
      scan_start_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_THRESHOLD:      thr_q <= cfg_wdata_i[THR_W-1:0];
          REG_LOOP_PERIOD:    lp_q  <= cfg_wdata_i[LOOP_W-1:0];
          REG_CAPTURE_PERIOD: cap_q <= cfg_wdata_i[CAP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_valid_i) begin
            state_q <= T_EXEC;
          end
        end
        T_EXEC: begin
          res_det_q <= 1'b0;
          res_ev_q  <= 1'b0;
          state_q   <= T_OUT;
          if (cmd_q == CMD_CAL) begin
            if (cal_cnt_q == CAL_LAST) begin
              ref_q     <= trimmed[SAMPLE_W+2:3];
              cal_cnt_q <= '0;
              cal_sum_q <= '0;
              cal_min_q <= SAMPLE_MAX;
              cal_max_q <= '0;
            end else begin
              cal_cnt_q <= cal_cnt_q + CAL_CNT_W'(1);
              cal_sum_q <= sum_new;
              cal_min_q <= min_new;
              cal_max_q <= max_new;
            end
          end else if (eval_hit) begin
            armed_q      <= 1'b1;
            res_ev_q     <= 1'b1;
            scan_start_q <= 1'b1;
            state_q      <= T_EVAL;
          end else begin
            if (thr_pos) begin
              wp_q <= wp_next;
            end
            if (armed_q) begin
              if (thr_q[THR_W-1]) begin
                res_det_q <= (dip < thr_ext);
              end else if (dip > thr_ext) begin
                cap_start_q <= now_q;
                armed_q     <= 1'b0;
              end
            end
          end
        end
        T_EVAL: begin
          if (scan_rsp.done) begin
            res_det_q <= scan_rsp.detected;
            state_q   <= T_OUT;
          end
        end
        T_OUT: begin
          if (can_load) begin
            out_valid_q <= 1'b1;
            det_out_q   <= res_det_q;
            ev_out_q    <= res_ev_q;
            ref_out_q   <= ref_q;
            state_q     <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign detected_o        = det_out_q;
  assign evaluated_o       = ev_out_q;
  assign reference_level_o = ref_out_q;

  // scan verdict only arrives while the top waits for it
  a_scan_done_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_rsp.done |-> state_q == T_EVAL)
    else $error("scan verdict outside evaluation");

  // evaluation re-arms before the scan runs
  a_eval_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == T_EVAL |-> armed_q && !wr_en)
    else $error("evaluation while disarmed or writing");

  // calibration beats never flag a detection or evaluation
  a_cal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_EXEC && cmd_q == CMD_CAL) |=> !res_det_q && !res_ev_q && state_q == T_OUT)
    else $error("calibration beat produced a flag");

endmodule

// ----- sv/ldgd_scan.sv -----
module ldgd_scan import ldgd_pkg::*; #(
  parameter int WINDOW_LENGTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [$clog2(WINDOW_LENGTH)-1:0] wr_addr_i,
  input  logic [SAMPLE_W-1:0]              wr_data_i,
  input  logic                             start_i,
  input  logic [$clog2(WINDOW_LENGTH)-1:0] wp_i,
  input  logic [LOOP_W-1:0]                loop_period_i,
  output scan_rsp_t                        rsp_o
);

  localparam int W  = WINDOW_LENGTH;
  localparam int AW = $clog2(W);
  localparam int LW = $clog2(W + 1);
  localparam int PW = LW + LOOP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MIN, S_RISE_SET, S_RISE, S_FALL_SET, S_FALL, S_MUL, S_CHK
  } state_e;

  // window storage, sync read
  logic [SAMPLE_W-1:0] mem [W];
  logic [W-1:0]        vld_q;
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_vld_q;

  state_e              state_q;
  logic [AW-1:0]       iss_k_q;
  logic                iss_on_q;
  logic                pend_q;
  logic [AW-1:0]       pend_k_q;
  logic [SAMPLE_W-1:0] best_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [AW-1:0]       j_q;
  logic [LW-1:0]       len_q;
  logic [PW-1:0]       prod_q;
  logic                fall_q;
  logic                done_q;
  logic                det_q;

  logic                rd_en;
  logic [AW-1:0]       rd_k;
  logic [AW:0]         rd_sum;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] val;
  logic                side_ok;

  // logical slot k sits at (wp + k) mod W
  assign rd_sum  = {1'b0, wp_i} + {1'b0, rd_k};
  assign rd_addr = (rd_sum >= (AW+1)'(W)) ? AW'(rd_sum - (AW+1)'(W)) : rd_sum[AW-1:0];
  assign val     = rd_vld_q ? rd_q : '0;
  assign side_ok = (prod_q >= PW'(SIDE_MIN_MS)) && (prod_q <= PW'(SIDE_MAX_MS));

  always_comb begin
    rd_en = 1'b0;
    rd_k  = iss_k_q;
    case (state_q)
      S_IDLE: begin
        rd_en = start_i;
        rd_k  = '0;
      end
      S_MIN, S_RISE, S_FALL: begin
        rd_en = iss_on_q;
      end
      S_RISE_SET: begin
        rd_en = 1'b1;
        rd_k  = j_q + AW'(1);
      end
      S_FALL_SET: begin
        rd_en = (j_q != '0);
        rd_k  = j_q - AW'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      state_q  <= S_IDLE;
      iss_k_q  <= '0;
      iss_on_q <= 1'b0;
      pend_q   <= 1'b0;
      pend_k_q <= '0;
      best_q   <= '0;
      prev_q   <= '0;
      j_q      <= '0;
      len_q    <= '0;
      prod_q   <= '0;
      fall_q   <= 1'b0;
      done_q   <= 1'b0;
      det_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      pend_q   <= rd_en;
      pend_k_q <= rd_k;
      done_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            iss_k_q  <= AW'(1);
            iss_on_q <= 1'b1;
            state_q  <= S_MIN;
          end
        end
        // first minimum over slots 0..W-2
        S_MIN: begin
          if (iss_on_q) begin
            iss_k_q  <= iss_k_q + AW'(1);
            iss_on_q <= (iss_k_q != AW'(W - 2));
          end
          if (pend_q) begin
            if (pend_k_q == '0 || val < best_q) begin
              best_q <= val;
              j_q    <= pend_k_q;
            end
            if (pend_k_q == AW'(W - 2)) begin
              state_q <= S_RISE_SET;
            end
          end
        end
        S_RISE_SET: begin
          prev_q   <= best_q;
          iss_k_q  <= j_q + AW'(2);
          iss_on_q <= (j_q != AW'(W - 2));
          fall_q   <= 1'b0;
          state_q  <= S_RISE;
        end
        S_RISE: begin
          if (iss_on_q) begin
            iss_k_q  <= iss_k_q + AW'(1);
            iss_on_q <= (iss_k_q != AW'(W - 1));
          end
          if (pend_q) begin
            prev_q <= val;
            if (val < prev_q) begin
              len_q   <= LW'(pend_k_q) - LW'(j_q);
              state_q <= S_MUL;
            end else if (pend_k_q == AW'(W - 1)) begin
              len_q   <= LW'(W) - LW'(j_q);
              state_q <= S_MUL;
            end
          end
        end
        S_FALL_SET: begin
          fall_q <= 1'b1;
          if (j_q == '0) begin
            len_q   <= LW'(1);
            state_q <= S_MUL;
          end else begin
            iss_k_q  <= j_q - AW'(2);
            iss_on_q <= (j_q != AW'(1));
            state_q  <= S_FALL;
          end
        end
        // walk down from j-1; prev_q holds slot(pend_k + 1)
        S_FALL: begin
          if (iss_on_q) begin
            iss_k_q  <= iss_k_q - AW'(1);
            iss_on_q <= (iss_k_q != '0);
          end
          if (pend_q) begin
            prev_q <= val;
            if (pend_k_q != j_q - AW'(1) && prev_q > val) begin
              len_q   <= LW'(j_q) - LW'(pend_k_q) - LW'(1);
              state_q <= S_MUL;
            end else if (pend_k_q == '0) begin
              len_q   <= LW'(j_q);
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= PW'(len_q) * PW'(loop_period_i);
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (!side_ok || fall_q) begin
            done_q  <= 1'b1;
            det_q   <= side_ok;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_FALL_SET;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o = '{done: done_q, detected: det_q};

endmodule

// ----- verif/light_dip_gesture_detector_tb.sv -----
`timescale 1ns / 100ps

module light_dip_gesture_detector_tb;
  import ldgd_pkg::*;

  localparam int WIN         = 64;
  localparam int N_RANDOM    = 950;
  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    logic                detected;
    logic                evaluated;
    logic [SAMPLE_W-1:0] level;
  } verdict_t;

  // Tracks detector state and queues the verdict each accepted beat should produce.
  class gesture_tracker;
    logic [SAMPLE_W-1:0] win_mem [WIN];
    int unsigned         head;        // oldest window slot
    bit                  armed;
    logic [TIME_W-1:0]   trig_ms;
    logic [SAMPLE_W-1:0] level;
    int unsigned         cal_n;
    int unsigned         cal_sum;
    logic [SAMPLE_W-1:0] cal_lo;
    logic [SAMPLE_W-1:0] cal_hi;
    int                  thr;
    int unsigned         loop_ms;
    int unsigned         cap_ms;
    verdict_t            verdicts_due[$];
    int                  errors;

    function new();
      foreach (win_mem[k]) win_mem[k] = '0;
      head    = 0;
      armed   = 1'b1;
      trig_ms = '0;
      level   = '0;
      cal_n   = 0;
      cal_sum = 0;
      cal_lo  = SAMPLE_MAX;
      cal_hi  = '0;
      thr     = 0;
      loop_ms = 32'(LOOP_RST);
      cap_ms  = 32'(CAP_RST);
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_THRESHOLD:      thr = int'($signed(d[THR_W-1:0]));
        REG_LOOP_PERIOD:    loop_ms = 32'(d[LOOP_W-1:0]);
        REG_CAPTURE_PERIOD: cap_ms = 32'(d[CAP_W-1:0]);
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] slot(int k);
      return win_mem[(head + k) % WIN];
    endfunction

    function bit side_fits(int len);
      longint d;
      d = longint'(len) * loop_ms;
      return d >= SIDE_MIN_MS && d <= SIDE_MAX_MS;
    endfunction

    // First minimum, then the rise after it and the fall before it.
    function bit gesture_in_window();
      int i;
      int j;
      j = 0;
      for (i = 0; i < WIN - 1; i++)
        if (slot(i) < slot(j)) j = i;
      for (i = j + 1; i < WIN; i++)
        if (slot(i) < slot(i - 1)) break;
      if (!side_fits(i - j)) return 1'b0;
      for (i = j - 1; i > 0; i--)
        if (slot(i) > slot(i - 1)) break;
      return side_fits(j - i);
    endfunction

    function void take_beat(logic cmd, logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] now);
      verdict_t          v;
      int                dip;
      logic [TIME_W-1:0] elapsed;
      v.detected  = 1'b0;
      v.evaluated = 1'b0;
      elapsed     = now - trig_ms;
      if (cmd == CMD_CAL) begin
        cal_sum += 32'(s);
        if (s < cal_lo) cal_lo = s;
        if (s > cal_hi) cal_hi = s;
        cal_n++;
        if (cal_n > int'(CAL_LAST)) begin
          level   = SAMPLE_W'((cal_sum - cal_lo - cal_hi) / 8);
          cal_n   = 0;
          cal_sum = 0;
          cal_lo  = SAMPLE_MAX;
          cal_hi  = '0;
        end
      end else if (!armed && elapsed >= cap_ms) begin
        // this beat is not stored, it only judges the window
        armed       = 1'b1;
        v.evaluated = 1'b1;
        v.detected  = gesture_in_window();
      end else begin
        if (thr > 0) head = (head + 1) % WIN;
        win_mem[(head + WIN - 1) % WIN] = s;
        if (armed) begin
          dip = int'(level) - int'(s);
          if (thr < 0) begin
            if (dip < thr) v.detected = 1'b1;
          end else if (dip > thr) begin
            trig_ms = now;
            armed   = 1'b0;
          end
        end
      end
      v.level = level;
      verdicts_due.push_back(v);
    endfunction

    function void match_result(logic det, logic ev, logic [SAMPLE_W-1:0] lvl);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result beat: detected=%0d evaluated=%0d reference_level=%0d",
               det, ev, lvl);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      if (det !== v.detected) begin
        $error("detected: expected %0d, got %0d", v.detected, det);
        errors++;
      end
      if (ev !== v.evaluated) begin
        $error("evaluated: expected %0d, got %0d", v.evaluated, ev);
        errors++;
      end
      if (lvl !== v.level) begin
        $error("reference_level: expected %0d, got %0d", v.level, lvl);
        errors++;
      end
    endfunction

    function bit empty();
      return verdicts_due.size() == 0;
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 command_i;
  logic [SAMPLE_W-1:0]  sample_i;
  logic [TIME_W-1:0]    now_ms_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 detected_o;
  logic                 evaluated_o;
  logic [SAMPLE_W-1:0]  reference_level_o;

  gesture_tracker    sb;
  logic [TIME_W-1:0] t_now;
  int                n_sent;
  int                quiet;
  bit                tx_idle;
  bit                rx_idle;

  light_dip_gesture_detector #(.WINDOW_LENGTH(WIN)) dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_beat(command_i, sample_i, now_ms_i);
      if (out_valid_o && !out_stall_i)
        sb.match_result(detected_o, evaluated_o, reference_level_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("light_dip_gesture_detector_tb NOT OK");
        $finish;
      end
    end
  end

  // result side: random stall before each beat while rx_idle is set
  initial begin : result_sink
    int hold;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = rx_idle ? $urandom_range(0, 7) : 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > int'(SAMPLE_MAX)) return SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  // Entered and left at a falling edge; valid stays up for a back-to-back beat.
  task automatic send_beat(logic cmd, logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    sample_i   <= s;
    now_ms_i   <= t;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (!sb.empty()) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic put_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= d;
    @(negedge clk_i);
    sb.set_reg(idx, d);
  endtask

  task automatic configure(int thr, int unsigned loop_ms, int unsigned cap_ms);
    wait_drained();
    cfg_we_i <= 1'b1;
    put_reg(REG_THRESHOLD, CFG_W'(thr));
    put_reg(REG_LOOP_PERIOD, CFG_W'(loop_ms));
    put_reg(REG_CAPTURE_PERIOD, CFG_W'(cap_ms));
    cfg_we_i <= 1'b0;
  endtask

  task automatic step_detect(int s);
    t_now += sb.loop_ms + (($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : 0);
    send_beat(CMD_DETECT, clamp_sample(s), t_now);
  endtask

  task automatic calibrate();
    int lvl;
    int n;
    lvl = $urandom_range(100, 1000);
    n   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 10;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(CMD_CAL, SAMPLE_W'($urandom_range(0, 1023)), t_now);
      else send_beat(CMD_CAL, clamp_sample(lvl + $urandom_range(0, 16) - 8), t_now);
    end
  endtask

  // Flat stretch, V-shaped dip, then flat until the capture closes and the window is judged.
  task automatic gesture_burst();
    int base;
    int depth;
    int n_dn;
    int n_up;
    int k;
    int guard;
    base  = int'(sb.level);
    depth = (sb.thr > 0 ? sb.thr : 0) + $urandom_range(1, 300);
    n_dn  = $urandom_range(1, 20);
    n_up  = $urandom_range(1, 20);
    repeat ($urandom_range(0, 30)) step_detect(base + $urandom_range(0, 4) - 2);
    for (k = 1; k <= n_dn; k++) step_detect(base - depth * k / n_dn);
    for (k = n_up - 1; k >= 0; k--) step_detect(base - depth * k / n_up);
    guard = 0;
    while (!sb.armed && guard < 200) begin
      if (guard == 30) t_now += sb.cap_ms;   // long capture periods
      step_detect(base + $urandom_range(0, 6) - 3);
      guard++;
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(5, 40)) begin
      if ($urandom_range(0, 7) == 0) t_now = $urandom();
      else t_now += $urandom_range(0, 2000);
      send_beat(($urandom_range(0, 5) != 0) ? CMD_DETECT : CMD_CAL,
                SAMPLE_W'($urandom_range(0, 1023)), t_now);
    end
  endtask

  task automatic directed_part();
    int k;
    // min and max are dropped: reference comes out at 512
    for (k = 0; k < 10; k++)
      send_beat(CMD_CAL, (k == 0) ? 10'd0 : (k == 1) ? SAMPLE_MAX : 10'd512, 32'd0);
    // zero threshold, no shift; capture started just before the time wraps
    send_beat(CMD_DETECT, SAMPLE_MAX, 32'd0);
    send_beat(CMD_DETECT, 10'd0, 32'hFFFF_FFF0);
    send_beat(CMD_DETECT, 10'd700, 32'h0000_03D7);
    send_beat(CMD_DETECT, 10'd600, 32'h0000_03D8);
    send_beat(CMD_DETECT, 10'd512, 32'hFFFF_FFFF);
    // negative threshold fires at once
    configure(-100, 1000, 0);
    send_beat(CMD_DETECT, SAMPLE_MAX, 32'd5);
    send_beat(CMD_DETECT, 10'd0, 32'd6);
    // zero loop period: the rising side already fails the duration test
    configure(5, 0, 0);
    send_beat(CMD_DETECT, 10'd0, 32'd7);
    send_beat(CMD_DETECT, SAMPLE_MAX, 32'd8);
    configure(-1023, 1, 65535);
    send_beat(CMD_DETECT, SAMPLE_MAX, 32'd9);
  endtask

  task automatic random_part();
    int start;
    int phase;
    int lp;
    int pick;
    start = n_sent;
    phase = 0;
    while (n_sent - start < N_RANDOM) begin
      case (phase % 6)
        0: configure(1023, 1000, 65535);
        1: configure(-1023, 1, 0);
        2: configure(0, 50, 1000);
        3: configure(-int'($urandom_range(1, 400)), $urandom_range(1, 1000),
                     $urandom_range(0, 3000));
        default: begin
          lp = $urandom_range(10, 100);
          configure($urandom_range(5, 150), lp, lp * $urandom_range(5, 30));
        end
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      calibrate();
      repeat (4) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) gesture_burst();
        else if (pick < 9) noise_burst();
        else wait_drained();
      end
      phase++;
    end
  endtask

  initial begin : stimulus
    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_THRESHOLD;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    command_i   = CMD_CAL;
    sample_i    = '0;
    now_ms_i    = '0;
    out_stall_i = 1'b0;
    n_sent      = 0;
    quiet       = 0;
    tx_idle     = 1'b1;
    rx_idle     = 1'b1;
    t_now       = $urandom();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_part();
    random_part();
    wait_drained();
    repeat (2 * WIN + 20) @(negedge clk_i);
    if (sb.errors == 0) $display("light_dip_gesture_detector_tb OK");
    else $display("light_dip_gesture_detector_tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ldgd_pkg.sv
sv/ldgd_scan.sv
sv/light_dip_gesture_detector.sv
verif/light_dip_gesture_detector_tb.sv
